// ----- hw/rtl/ssa_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the swap slot allocator.
`default_nettype none

package ssa_pkg;

    // Slot store geometry
    localparam int MAX_SLOTS = 1024;
    localparam int SLOT_AW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int COUNT_W   = $clog2(MAX_SLOTS + 1);

    // Page geometry
    localparam int SECTORS_PER_PAGE = 8;
    localparam int SECTOR_BYTES     = 512;
    localparam int IDX_W            = (SECTORS_PER_PAGE > 1) ? $clog2(SECTORS_PER_PAGE) : 1;

    // Field widths
    localparam int SECTOR_W = 13;
    localparam int DISK_W   = 14;
    localparam int ADDR_W   = 32;

    localparam logic [DISK_W-1:0] SECTOR_LIMIT = DISK_W'(8192);
    localparam logic [DISK_W-1:0] DISK_RESET   = DISK_W'(8192);

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_SLOT  = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    // Request kinds
    typedef enum logic {
        OP_SWAP_OUT = 1'b0,
        OP_SWAP_IN  = 1'b1
    } op_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;   // take the request and start the free list read
        logic decide;    // pick the slot and update the free list / bump pointer
        logic load;      // move the next result into the output register
    } ssa_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;    // output register can take a result this cycle
        logic last_beat;   // the next result loaded ends the request
        logic fifo_empty;
        logic fifo_full;
    } ssa_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/swap_slot_allocator.sv -----
// Top level of the swap slot allocator: controller, datapath and stream ports.
//
// Requests arrive on the s_ stream: s_tuser is the operation (0 swap out, 1 swap in),
// s_tdata carries the page buffer address and, for swap in, the slot's first sector.
// Each request produces one result per sector of the page on the m_ stream (eight by
// default): a sector write for swap out, a sector read for swap in, with m_tlast on
// the final one. A swap out that finds no free slot produces a single result with
// status 1. A swap in into a full free list still produces its reads, with status 2.
// The disk size register is written through cfg_wr_en / cfg_wr_data; the user must
// write it only while idle, and the block itself does not enforce this. After a
// request transfer, the decide state picks the slot, then the emit state loads the
// first result into the output register once it is free. The next request is taken
// once the last result is in the output register; the decide state after the free
// list read and the registered rise of s_tready are the overhead per request.
// When the receiver stalls, the output register holds its result and the sequencer
// waits; results are never dropped. Synchronous active-low reset empties the free
// list, rewinds the bump pointer to sector 0 and sets the disk size to 8192 sectors;
// the slot RAM itself is not cleared.
`default_nettype none

module swap_slot_allocator
    import ssa_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // Disk size register
    input  wire logic              cfg_wr_en,
    input  wire logic [DISK_W-1:0] cfg_wr_data,
    // Requests
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [47:0]       s_tdata,   // page_address[31:0], slot_location[44:32]
    input  wire logic [0:0]        s_tuser,   // operation[0]
    // Results
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [63:0]            m_tdata,   // sector_address[12:0], buffer_address[44:13],
                                              // slot_location_res[57:45]
    output logic [2:0]             m_tuser,   // status[1:0], is_write[2]
    output logic                   m_tlast
);

    ssa_cmd_t            cmd;
    ssa_stat_t           stat;
    logic [1:0]          res_status;
    logic                res_is_write;
    logic [SECTOR_W-1:0] res_sector;
    logic [ADDR_W-1:0]   res_buffer;
    logic [SECTOR_W-1:0] res_slot;

    ssa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ssa_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_op        (s_tuser[0]),
        .s_page      (s_tdata[31:0]),
        .s_slot      (s_tdata[44:32]),
        .cmd         (cmd),
        .stat        (stat),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_status    (res_status),
        .m_is_write  (res_is_write),
        .m_sector    (res_sector),
        .m_buffer    (res_buffer),
        .m_slot_res  (res_slot),
        .m_last      (m_tlast)
    );

    // Pack result fields
    assign m_tdata = {6'd0, res_slot, res_buffer, res_sector};
    assign m_tuser = {res_is_write, res_status};

    // A taken request blocks the input until its results are through
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready while a request is in progress");

    // Results are only loaded into a free output register
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> stat.out_free)
        else $error("result loaded over a pending one");

    // A no-slot result is always the only one of its request
    a_fail_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[1:0] == STATUS_NO_SLOT) |-> m_tlast && !m_tuser[2])
        else $error("no-slot result not final");

    // The free list cannot be both empty and full
    a_fifo_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        !(stat.fifo_empty && stat.fifo_full))
        else $error("free list count inconsistent");

endmodule

`default_nettype wire

// ----- hw/rtl/ssa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ssa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    aclk,
    input  wire logic                                    wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                        wr_data,
    input  wire logic                                    rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ssa_ctrl.sv -----
// Request sequencer: accepts a request, triggers slot selection, then paces result loading.
`default_nettype none

module ssa_ctrl
    import ssa_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire ssa_stat_t stat,
    output ssa_cmd_t       cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    assign s_tready = ready_reg;

    // Issue commands from the current state
    always_comb begin
        cmd         = '0;
        cmd.capture = ready_reg && s_tvalid;
        cmd.decide  = (state_reg == ST_DECIDE);
        cmd.load    = (state_reg == ST_EMIT) && stat.out_free;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        ready_next = ready_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.capture) begin
                    state_next = ST_DECIDE;
                    ready_next = 1'b0;
                end
            end
            ST_DECIDE: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (cmd.load && stat.last_beat) begin
                    state_next = ST_IDLE;
                    ready_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    // Hold state and ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ssa_datapath.sv -----
// Free slot list, bump pointer, disk size register, result counters and output register.
`default_nettype none

module ssa_datapath
    import ssa_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [DISK_W-1:0]   cfg_wr_data,
    input  wire logic                s_op,
    input  wire logic [ADDR_W-1:0]   s_page,
    input  wire logic [SECTOR_W-1:0] s_slot,
    input  wire ssa_cmd_t            cmd,
    output ssa_stat_t                stat,
    input  wire logic                m_tready,
    output logic                     m_tvalid,
    output logic [1:0]               m_status,
    output logic                     m_is_write,
    output logic [SECTOR_W-1:0]      m_sector,
    output logic [ADDR_W-1:0]        m_buffer,
    output logic [SECTOR_W-1:0]      m_slot_res,
    output logic                     m_last
);

    // Persistent allocator state
    logic [DISK_W-1:0]  disk_reg;
    logic [SLOT_AW-1:0] head_reg, head_next;
    logic [SLOT_AW-1:0] tail_reg, tail_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [DISK_W-1:0]  bump_reg, bump_next;

    // Per-request working registers
    logic                op_reg;
    logic [ADDR_W-1:0]   buf_reg, buf_next;
    logic [SECTOR_W-1:0] loc_reg;
    logic [SECTOR_W-1:0] slot_reg, slot_next;
    logic [SECTOR_W-1:0] sector_reg, sector_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [1:0]          status_reg, status_next;
    logic                fail_reg, fail_next;

    // Output register
    logic                m_valid_reg, m_valid_next;
    logic [1:0]          m_status_reg;
    logic                m_is_write_reg;
    logic [SECTOR_W-1:0] m_sector_reg;
    logic [ADDR_W-1:0]   m_buffer_reg;
    logic [SECTOR_W-1:0] m_slot_reg;
    logic                m_last_reg;

    logic                fifo_empty, fifo_full;
    logic                ram_wr_en;
    logic [SECTOR_W-1:0] ram_rd_data;
    logic [DISK_W-1:0]   bound;
    logic                bump_fits;
    logic                beat_last;

    assign fifo_empty = (count_reg == '0);
    assign fifo_full  = (count_reg == COUNT_W'(MAX_SLOTS));
    assign bound      = (disk_reg > SECTOR_LIMIT) ? SECTOR_LIMIT : disk_reg;
    assign bump_fits  = ({1'b0, bump_reg} + (DISK_W+1)'(SECTORS_PER_PAGE)) <= {1'b0, bound};
    assign beat_last  = fail_reg || (idx_reg == IDX_W'(SECTORS_PER_PAGE - 1));
    assign ram_wr_en  = cmd.decide && (op_reg == OP_SWAP_IN) && !fifo_full;

    // Free slot store; head is read on every capture so the entry is ready at decide
    ssa_ram #(
        .WIDTH (SECTOR_W),
        .DEPTH (MAX_SLOTS)
    ) u_free_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (tail_reg),
        .wr_data (loc_reg),
        .rd_en   (cmd.capture),
        .rd_addr (head_reg),
        .rd_data (ram_rd_data)
    );

    // Pick the slot and update the list and bump pointer
    always_comb begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        bump_next   = bump_reg;
        slot_next   = slot_reg;
        status_next = status_reg;
        fail_next   = fail_reg;
        if (cmd.decide) begin
            fail_next   = 1'b0;
            status_next = STATUS_OK;
            if (op_reg == OP_SWAP_OUT) begin
                if (!fifo_empty) begin
                    slot_next  = ram_rd_data;
                    head_next  = (head_reg == SLOT_AW'(MAX_SLOTS - 1)) ? '0 : head_reg + 1'b1;
                    count_next = count_reg - 1'b1;
                end else if (bump_fits) begin
                    slot_next = bump_reg[SECTOR_W-1:0];
                    bump_next = bump_reg + DISK_W'(SECTORS_PER_PAGE);
                end else begin
                    fail_next   = 1'b1;
                    status_next = STATUS_NO_SLOT;
                end
            end else begin
                slot_next = loc_reg;
                if (fifo_full) begin
                    status_next = STATUS_OVERFLOW;
                end else begin
                    tail_next  = (tail_reg == SLOT_AW'(MAX_SLOTS - 1)) ? '0 : tail_reg + 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
        end
    end

    // Step the sector, buffer and index counters
    always_comb begin
        sector_next = sector_reg;
        buf_next    = buf_reg;
        idx_next    = idx_reg;
        if (cmd.decide) begin
            sector_next = slot_next;
            idx_next    = '0;
        end else if (cmd.load) begin
            sector_next = sector_reg + 1'b1;
            buf_next    = buf_reg + ADDR_W'(SECTOR_BYTES);
            idx_next    = idx_reg + 1'b1;
        end
    end

    // Output register valid: set on load, drop on transfer
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            disk_reg    <= DISK_RESET;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            bump_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                disk_reg <= cfg_wr_data;
            end
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            bump_reg    <= bump_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg  <= s_op;
            loc_reg <= s_slot;
        end
        if (cmd.capture) begin
            buf_reg <= s_page;
        end else begin
            buf_reg <= buf_next;
        end
        slot_reg   <= slot_next;
        sector_reg <= sector_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        fail_reg   <= fail_next;
        if (cmd.load) begin
            m_status_reg   <= status_reg;
            m_last_reg     <= beat_last;
            m_is_write_reg <= fail_reg ? 1'b0 : (op_reg == OP_SWAP_OUT);
            m_sector_reg   <= fail_reg ? '0 : sector_reg;
            m_buffer_reg   <= fail_reg ? '0 : buf_reg;
            m_slot_reg     <= fail_reg ? '0 : slot_reg;
        end
    end

    assign stat.out_free   = !m_valid_reg || m_tready;
    assign stat.last_beat  = beat_last;
    assign stat.fifo_empty = fifo_empty;
    assign stat.fifo_full  = fifo_full;

    assign m_tvalid   = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_is_write = m_is_write_reg;
    assign m_sector   = m_sector_reg;
    assign m_buffer   = m_buffer_reg;
    assign m_slot_res = m_slot_reg;
    assign m_last     = m_last_reg;

endmodule

`default_nettype wire

// ----- tb/sv/tb_swap_slot_allocator.sv -----
// Self-checking testbench for swap_slot_allocator with an in-bench slot allocation predictor.
`default_nettype none

module tb_swap_slot_allocator;
    import ssa_pkg::*;

    localparam int STALL_LIMIT = 2000;

    // One sector command as seen on the result stream
    typedef struct {
        status_t     status;
        logic        is_write;
        logic [12:0] sector;
        logic [31:0] buffer;
        logic [12:0] slot;
        logic        last;
    } sector_cmd_t;

    // Slot allocation predictor and store of pending sector commands
    class slot_scoreboard;
        logic [12:0]       free_slots[MAX_SLOTS];
        int unsigned       head;
        int unsigned       tail;
        int unsigned       count;
        logic [13:0]       next_sector;
        logic [13:0]       disk_sectors;
        sector_cmd_t       pending_q[$];
        int                errors;

        function new();
            head         = 0;
            tail         = 0;
            count        = 0;
            next_sector  = '0;
            disk_sectors = DISK_RESET;
            errors       = 0;
        endfunction

        function int outstanding();
            return pending_q.size();
        endfunction

        // A swap out fails when nothing is free and the next slot would pass the disk end
        function bit swap_out_fails();
            int bound;
            bound = (disk_sectors > SECTOR_LIMIT) ? int'(SECTOR_LIMIT) : int'(disk_sectors);
            return (count == 0) && (int'(next_sector) + SECTORS_PER_PAGE > bound);
        endfunction

        // Queue one command per sector of the page
        function void queue_page(status_t st, logic wr, logic [12:0] slot,
                                 logic [31:0] page);
            sector_cmd_t c;
            for (int i = 0; i < SECTORS_PER_PAGE; i++) begin
                c.status   = st;
                c.is_write = wr;
                c.sector   = slot + 13'(i);
                c.buffer   = page + 32'(SECTOR_BYTES * i);
                c.slot     = slot;
                c.last     = (i == SECTORS_PER_PAGE - 1);
                pending_q.push_back(c);
            end
        endfunction

        // Advance the allocator state for one accepted request
        function void note_request(op_t op, logic [31:0] page, logic [12:0] loc);
            logic [12:0] slot;
            sector_cmd_t c;
            if (op == OP_SWAP_OUT) begin
                if (count > 0) begin
                    slot  = free_slots[head];
                    head  = (head + 1) % MAX_SLOTS;
                    count = count - 1;
                end else if (swap_out_fails()) begin
                    c.status   = STATUS_NO_SLOT;
                    c.is_write = 1'b0;
                    c.sector   = '0;
                    c.buffer   = '0;
                    c.slot     = '0;
                    c.last     = 1'b1;
                    pending_q.push_back(c);
                    return;
                end else begin
                    slot        = next_sector[12:0];
                    next_sector = next_sector + 14'(SECTORS_PER_PAGE);
                end
                queue_page(STATUS_OK, 1'b1, slot, page);
            end else if (count >= MAX_SLOTS) begin
                // drop the slot, still issue the reads
                queue_page(STATUS_OVERFLOW, 1'b0, loc, page);
            end else begin
                free_slots[tail] = loc;
                tail  = (tail + 1) % MAX_SLOTS;
                count = count + 1;
                queue_page(STATUS_OK, 1'b0, loc, page);
            end
        endfunction

        task report(string what, logic [31:0] got_v, logic [31:0] want_v);
            if (errors < 100)
                $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got_v, want_v);
            errors++;
        endtask

        // Compare one result transfer with the oldest pending command
        task check_result(sector_cmd_t got);
            sector_cmd_t want;
            if (pending_q.size() == 0) begin
                report("result with none pending, sector", got.sector, 32'd0);
                return;
            end
            want = pending_q.pop_front();
            if (got.status !== want.status)     report("status", got.status, want.status);
            if (got.is_write !== want.is_write) report("is_write", got.is_write, want.is_write);
            if (got.sector !== want.sector)     report("sector_address", got.sector, want.sector);
            if (got.buffer !== want.buffer)     report("buffer_address", got.buffer, want.buffer);
            if (got.slot !== want.slot)         report("slot_location", got.slot, want.slot);
            if (got.last !== want.last)         report("last", got.last, want.last);
        endtask
    endclass

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [DISK_W-1:0] cfg_wr_data = '0;
    logic              s_tvalid    = 1'b0;
    logic              s_tready;
    logic [47:0]       s_tdata     = '0;   // page_address[31:0], slot_location[44:32]
    logic [0:0]        s_tuser     = '0;   // operation[0]
    logic              m_tvalid;
    logic              m_tready    = 1'b0;
    logic [63:0]       m_tdata;            // sector_address[12:0], buffer_address[44:13],
                                           // slot_location_res[57:45]
    logic [2:0]        m_tuser;            // status[1:0], is_write[2]
    logic              m_tlast;

    slot_scoreboard sb = new();
    int             cycle_count = 0;
    int             quiet_cycles = 0;

    swap_slot_allocator DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always #2 aclk = ~aclk;

    // Idle a third of the time, except in a long steady stretch of every window
    function automatic bit take_break();
        if ((cycle_count % 3000) >= 2300)
            return 1'b0;
        return $urandom_range(99) < 33;
    endfunction

    // Check result transfers, pace the receiver and watch for a hang
    always @(posedge aclk) begin
        sector_cmd_t got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.status   = status_t'(m_tuser[1:0]);
                got.is_write = m_tuser[2];
                got.sector   = m_tdata[12:0];
                got.buffer   = m_tdata[44:13];
                got.slot     = m_tdata[57:45];
                got.last     = m_tlast;
                sb.check_result(got);
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            m_tready    <= !take_break();
            cycle_count <= cycle_count + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("swap_slot_allocator test failed");
                $finish;
            end
        end
    end

    // Present one request and hold it until the transfer; leave valid high
    task automatic send(op_t op, logic [31:0] page, logic [12:0] loc);
        while (take_break()) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, loc, page};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_request(op, page, loc);
    endtask

    // Wait until every pending command has come out and the block has settled
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_disk_sectors(logic [DISK_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.disk_sectors = value;
    endtask

    // Mixed requests; half the releases name slot-aligned sectors
    task automatic random_run(int n, int swap_in_pct);
        op_t         op;
        logic [12:0] loc;
        repeat (n) begin
            op  = ($urandom_range(99) < swap_in_pct) ? OP_SWAP_IN : OP_SWAP_OUT;
            loc = $urandom_range(1) ? 13'($urandom_range(8191))
                                    : {10'($urandom_range(1023)), 3'b000};
            send(op, $urandom(), loc);
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Two slots of disk: bump allocation, exhaustion, wraps, reuse, duplicates
        write_disk_sectors(14'd16);
        send(OP_SWAP_OUT, 32'h0000_0000, 13'h1FFF);
        send(OP_SWAP_OUT, 32'hFFFF_FFFF, 13'h0000);
        send(OP_SWAP_OUT, 32'h1234_5678, 13'h0000);
        send(OP_SWAP_IN,  32'hFFFF_F000, 13'h1FFF);
        send(OP_SWAP_IN,  32'h0000_0000, 13'h0000);
        send(OP_SWAP_IN,  32'h8000_0000, 13'h0000);
        send(OP_SWAP_OUT, 32'h0000_0200, 13'h0000);
        send(OP_SWAP_OUT, 32'h7FFF_FE00, 13'h0000);
        send(OP_SWAP_OUT, 32'hDEAD_BEEF, 13'h0000);
        send(OP_SWAP_OUT, 32'h0000_0001, 13'h0000);
        send(OP_SWAP_IN,  32'hAAAA_AAAA, 13'h0AAA);
        send(OP_SWAP_IN,  32'h5555_5555, 13'h1555);
        send(OP_SWAP_OUT, 32'h0F0F_0F0F, 13'h0000);
        send(OP_SWAP_OUT, 32'hF0F0_F0F0, 13'h0000);
        drain();

        // Empty disk: only released slots can be handed out
        write_disk_sectors(14'd0);
        send(OP_SWAP_OUT, 32'h0000_1000, 13'h0000);
        send(OP_SWAP_IN,  32'h0000_2000, 13'h0008);
        send(OP_SWAP_OUT, 32'h0000_3000, 13'h0000);
        send(OP_SWAP_OUT, 32'h0000_4000, 13'h0000);
        drain();

        // Random traffic under several disk sizes
        write_disk_sectors(DISK_RESET);
        random_run(134, 40);
        drain();
        write_disk_sectors(14'($urandom_range(16383)));
        random_run(134, 50);
        drain();
        write_disk_sectors(14'd203);
        random_run(134, 50);
        drain();

        repeat (12) @(posedge aclk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("swap_slot_allocator test passed");
        end else begin
            $display("swap_slot_allocator test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
